@@ hw/rtl/env_sensor_compensation_assert.svh @@
// assertion macros for the environmental sensor compensation block
// used by the port checker; expects clk and rst_n in scope
`ifndef ENV_SENSOR_COMPENSATION_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_ASSERT_SVH

// check held outside reset
`define ESC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: port check failed");

// check held at every edge, reset included
`define ESC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: port check failed");

`endif

@@ hw/rtl/esc_pkg.sv @@
// shared types, register indexes and arithmetic helpers for the
// environmental sensor compensation block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

  localparam int DivBits = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] REG_TEMP    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESS_A = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESS_B = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PRESS_9 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HUM_A   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HUM_B   = 3'd5;

  localparam logic [31:0] HumMax = 32'd419430400;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } esc_in_t;

  typedef struct packed {
    logic signed [17:0] temperature_centi;
    logic [31:0]        air_pressure;
    logic               pressure_valid;
    logic [16:0]        humidity_q10;
  } esc_out_t;

  // fields that ride along the divider
  typedef struct packed {
    logic [17:0] temp;
    logic [16:0] hum;
    logic        dbl;
    logic        dz;
  } esc_side_t;

  typedef struct packed {
    logic            vld;
    logic [31:0]     rem;
    logic [31:0]     quo;
    logic [31:0]     num;
    logic [31:0]     den;
    esc_side_t       side;
  } esc_div_stage_t;

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic [31:0] sra32(input logic [31:0] x, input logic [4:0] n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/env_sensor_compensation.sv @@
// pipeline from input transfer to result: 12 front stages, 32 divider stages
// and 3 back stages including the output register
// throughput: one transfer per cycle; the whole pipe holds while the output is stalled
// reset: synchronous active-low rst_n clears valid bits and calibration registers
// depends on esc_pkg and esc_div
`timescale 1ns / 1ps
`default_nettype none

module env_sensor_compensation (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire esc_pkg::esc_in_t            in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output esc_pkg::esc_out_t                out_data,
  input  wire logic                        cfg_we,
  input  wire logic [esc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [esc_pkg::CfgDataW-1:0] cfg_data
);

  logic [47:0] temp_coeffs_r;
  logic [63:0] press_a_r;
  logic [63:0] press_b_r;
  logic [15:0] press_9_r;
  logic [31:0] hum_a_r;
  logic [39:0] hum_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_a_r     <= '0;
      press_b_r     <= '0;
      press_9_r     <= '0;
      hum_a_r       <= '0;
      hum_b_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        esc_pkg::REG_TEMP:    temp_coeffs_r <= cfg_data[47:0];
        esc_pkg::REG_PRESS_A: press_a_r     <= cfg_data;
        esc_pkg::REG_PRESS_B: press_b_r     <= cfg_data;
        esc_pkg::REG_PRESS_9: press_9_r     <= cfg_data[15:0];
        esc_pkg::REG_HUM_A:   hum_a_r       <= cfg_data[31:0];
        esc_pkg::REG_HUM_B:   hum_b_r       <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
  assign t1 = {16'b0, temp_coeffs_r[15:0]};
  assign t2 = esc_pkg::sx16(temp_coeffs_r[31:16]);
  assign t3 = esc_pkg::sx16(temp_coeffs_r[47:32]);
  assign p1 = {16'b0, press_a_r[15:0]};
  assign p2 = esc_pkg::sx16(press_a_r[31:16]);
  assign p3 = esc_pkg::sx16(press_a_r[47:32]);
  assign p4 = esc_pkg::sx16(press_a_r[63:48]);
  assign p5 = esc_pkg::sx16(press_b_r[15:0]);
  assign p6 = esc_pkg::sx16(press_b_r[31:16]);
  assign p7 = esc_pkg::sx16(press_b_r[47:32]);
  assign p8 = esc_pkg::sx16(press_b_r[63:48]);
  assign p9 = esc_pkg::sx16(press_9_r);
  assign h1 = {24'b0, hum_a_r[7:0]};
  assign h2 = esc_pkg::sx16(hum_a_r[23:8]);
  assign h3 = {24'b0, hum_a_r[31:24]};
  assign h4 = esc_pkg::sx16(hum_b_r[15:0]);
  assign h5 = esc_pkg::sx16(hum_b_r[31:16]);
  assign h6 = esc_pkg::sx8(hum_b_r[39:32]);

  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // valid bits of the front and back stages and of the divider output
  logic [12:1] vld_r;
  logic        div_vld;
  logic [3:1]  bvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      bvld_r <= '0;
    end else if (en) begin
      vld_r  <= {vld_r[11:1], in_valid};
      bvld_r <= {bvld_r[2:1], div_vld};
    end
  end
  assign out_valid = bvld_r[3];

  // stage registers
  logic [31:0] s1_ta_r, s1_dd_r;
  logic [19:0] s1_adcp_r, s2_adcp_r, s3_adcp_r, s4_adcp_r, s5_adcp_r, s6_adcp_r, s7_adcp_r;
  logic [15:0] s1_adch_r, s2_adch_r, s3_adch_r, s4_adch_r, s5_adch_r;
  logic [31:0] s2_a_r, s2_bb_r;
  logic [31:0] s3_fine_r;
  logic [31:0] s4_t5_r, s4_pa_r, s4_hx_r;
  logic [17:0] s5_temp_r, s6_temp_r, s7_temp_r, s8_temp_r, s9_temp_r, s10_temp_r, s11_temp_r;
  logic [17:0] s12_temp_r;
  logic [31:0] s5_qq_r, s5_ap5_r, s5_ap2_r, s5_h5x_r, s5_xh6_r, s5_xh3_r;
  logic [31:0] s6_pb1_r, s6_p3q_r, s6_ap5_r, s6_ap2_r, s6_hu_r, s6_hm_r;
  logic [31:0] s7_pb_r, s7_pa2_r, s7_hv1_r, s7_hu_r;
  logic [31:0] s8_pa3_r, s8_pnum_r, s8_hv_r, s8_hu_r;
  logic [31:0] s9_den_r, s9_pn_r, s9_hx2_r;
  logic [31:0] s10_num_r, s10_den_r, s10_hx2_r, s10_yy_r;
  logic        s10_dbl_r, s11_dbl_r, s12_dbl_r;
  logic [31:0] s11_num_r, s11_den_r, s11_hx2_r, s11_t_r;
  logic [31:0] s12_num_r, s12_den_r;
  logic [16:0] s12_hum_r;

  logic [31:0] s1_d, s5_q, s5_t, s10_y, s12_x, s12_clamp;
  assign s1_d  = {16'b0, in_data.raw_temperature[19:4]} - t1;
  assign s5_q  = esc_pkg::sra32(s4_pa_r, 5'd2);
  assign s5_t  = esc_pkg::sra32(s4_t5_r + 32'd128, 5'd8);
  assign s10_y = esc_pkg::sra32(s9_hx2_r, 5'd15);
  assign s12_x = s11_hx2_r - esc_pkg::sra32(s11_t_r, 5'd4);
  assign s12_clamp = s12_x[31] ? 32'd0 : ((s12_x > esc_pkg::HumMax) ? esc_pkg::HumMax : s12_x);

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: temperature products
      s1_ta_r <= esc_pkg::mul32({15'b0, in_data.raw_temperature[19:3]} - {t1[30:0], 1'b0}, t2);
      s1_dd_r <= esc_pkg::mul32(s1_d, s1_d);
      s1_adcp_r <= in_data.raw_pressure;
      s1_adch_r <= in_data.raw_humidity;
      // stage 2
      s2_a_r  <= esc_pkg::sra32(s1_ta_r, 5'd11);
      s2_bb_r <= esc_pkg::mul32(esc_pkg::sra32(s1_dd_r, 5'd12), t3);
      s2_adcp_r <= s1_adcp_r;
      s2_adch_r <= s1_adch_r;
      // stage 3: fine term
      s3_fine_r <= s2_a_r + esc_pkg::sra32(s2_bb_r, 5'd14);
      s3_adcp_r <= s2_adcp_r;
      s3_adch_r <= s2_adch_r;
      // stage 4
      s4_t5_r <= {s3_fine_r[29:0], 2'b00} + s3_fine_r;
      s4_pa_r <= esc_pkg::sra32(s3_fine_r, 5'd1) - 32'd64000;
      s4_hx_r <= s3_fine_r - 32'd76800;
      s4_adcp_r <= s3_adcp_r;
      s4_adch_r <= s3_adch_r;
      // stage 5
      s5_temp_r <= s5_t[17:0];
      s5_qq_r  <= esc_pkg::mul32(s5_q, s5_q);
      s5_ap5_r <= esc_pkg::mul32(s4_pa_r, p5);
      s5_ap2_r <= esc_pkg::mul32(p2, s4_pa_r);
      s5_h5x_r <= esc_pkg::mul32(h5, s4_hx_r);
      s5_xh6_r <= esc_pkg::mul32(s4_hx_r, h6);
      s5_xh3_r <= esc_pkg::mul32(s4_hx_r, h3);
      s5_adcp_r <= s4_adcp_r;
      s5_adch_r <= s4_adch_r;
      // stage 6
      s6_temp_r <= s5_temp_r;
      s6_pb1_r <= esc_pkg::mul32(esc_pkg::sra32(s5_qq_r, 5'd11), p6);
      s6_p3q_r <= esc_pkg::mul32(p3, esc_pkg::sra32(s5_qq_r, 5'd13));
      s6_ap5_r <= s5_ap5_r;
      s6_ap2_r <= s5_ap2_r;
      s6_hu_r  <= esc_pkg::sra32({2'b0, s5_adch_r, 14'b0} - {h4[11:0], 20'b0}
                                 - s5_h5x_r + 32'd16384, 5'd15);
      s6_hm_r  <= esc_pkg::mul32(esc_pkg::sra32(s5_xh6_r, 5'd10),
                                 esc_pkg::sra32(s5_xh3_r, 5'd11) + 32'd32768);
      s6_adcp_r <= s5_adcp_r;
      // stage 7
      s7_temp_r <= s6_temp_r;
      s7_pb_r  <= esc_pkg::sra32(s6_pb1_r + {s6_ap5_r[30:0], 1'b0}, 5'd2) + {p4[15:0], 16'b0};
      s7_pa2_r <= esc_pkg::sra32(esc_pkg::sra32(s6_p3q_r, 5'd3)
                                 + esc_pkg::sra32(s6_ap2_r, 5'd1), 5'd18);
      s7_hv1_r <= esc_pkg::mul32(esc_pkg::sra32(s6_hm_r, 5'd10) + 32'd2097152, h2);
      s7_hu_r  <= s6_hu_r;
      s7_adcp_r <= s6_adcp_r;
      // stage 8
      s8_temp_r <= s7_temp_r;
      s8_pa3_r  <= esc_pkg::mul32(32'd32768 + s7_pa2_r, p1);
      s8_pnum_r <= (32'd1048576 - {12'b0, s7_adcp_r}) - esc_pkg::sra32(s7_pb_r, 5'd12);
      s8_hv_r   <= esc_pkg::sra32(s7_hv1_r + 32'd8192, 5'd14);
      s8_hu_r   <= s7_hu_r;
      // stage 9
      s9_temp_r <= s8_temp_r;
      s9_den_r  <= esc_pkg::sra32(s8_pa3_r, 5'd15);
      s9_pn_r   <= esc_pkg::mul32(s8_pnum_r, 32'd3125);
      s9_hx2_r  <= esc_pkg::mul32(s8_hu_r, s8_hv_r);
      // stage 10
      s10_temp_r <= s9_temp_r;
      s10_dbl_r  <= s9_pn_r[31];
      s10_num_r  <= s9_pn_r[31] ? s9_pn_r : {s9_pn_r[30:0], 1'b0};
      s10_den_r  <= s9_den_r;
      s10_hx2_r  <= s9_hx2_r;
      s10_yy_r   <= esc_pkg::mul32(s10_y, s10_y);
      // stage 11
      s11_temp_r <= s10_temp_r;
      s11_dbl_r  <= s10_dbl_r;
      s11_num_r  <= s10_num_r;
      s11_den_r  <= s10_den_r;
      s11_hx2_r  <= s10_hx2_r;
      s11_t_r    <= esc_pkg::mul32(esc_pkg::sra32(s10_yy_r, 5'd7), h1);
      // stage 12: humidity clamp
      s12_temp_r <= s11_temp_r;
      s12_dbl_r  <= s11_dbl_r;
      s12_num_r  <= s11_num_r;
      s12_den_r  <= s11_den_r;
      s12_hum_r  <= s12_clamp[28:12];
    end
  end

  esc_pkg::esc_side_t div_side_in, div_side;
  logic [31:0]        div_quo;

  always_comb begin
    div_side_in.temp = s12_temp_r;
    div_side_in.hum  = s12_hum_r;
    div_side_in.dbl  = s12_dbl_r;
    div_side_in.dz   = (s12_den_r == 32'd0);
  end

  esc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_r[12]),
    .in_num   (s12_num_r),
    .in_den   (s12_den_r),
    .in_side  (div_side_in),
    .out_vld  (div_vld),
    .out_quo  (div_quo),
    .out_side (div_side)
  );

  // back stages: pressure correction
  logic [31:0] b1_p;
  logic [31:0] d1_p_r, d1_pp_r, d1_v1_r;
  logic [31:0] d2_p_r, d2_u1_r, d2_v1_r;
  esc_pkg::esc_side_t d1_side_r, d2_side_r;
  logic [31:0] d3_press;
  esc_pkg::esc_out_t out_nxt, out_r;

  assign b1_p = div_side.dbl ? {div_quo[30:0], 1'b0} : div_quo;

  always_comb begin
    d3_press = d2_p_r + esc_pkg::sra32(esc_pkg::sra32(d2_u1_r, 5'd12)
                                       + esc_pkg::sra32(d2_v1_r, 5'd13) + p7, 5'd4);
    out_nxt.temperature_centi = $signed(d2_side_r.temp);
    out_nxt.air_pressure      = d2_side_r.dz ? 32'd0 : d3_press;
    out_nxt.pressure_valid    = !d2_side_r.dz;
    out_nxt.humidity_q10      = d2_side_r.hum;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_p_r    <= b1_p;
      d1_pp_r   <= esc_pkg::mul32({3'b0, b1_p[31:3]}, {3'b0, b1_p[31:3]});
      d1_v1_r   <= esc_pkg::mul32({2'b0, b1_p[31:2]}, p8);
      d1_side_r <= div_side;
      d2_p_r    <= d1_p_r;
      d2_u1_r   <= esc_pkg::mul32(p9, {13'b0, d1_pp_r[31:13]});
      d2_v1_r   <= d1_v1_r;
      d2_side_r <= d1_side_r;
      out_r     <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

@@ hw/rtl/esc_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// depends on esc_pkg; side fields travel with each transfer
`timescale 1ns / 1ps
`default_nettype none

module esc_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_vld,
  input  wire logic [31:0]       in_num,
  input  wire logic [31:0]       in_den,
  input  wire esc_pkg::esc_side_t in_side,
  output logic                   out_vld,
  output logic [31:0]            out_quo,
  output esc_pkg::esc_side_t     out_side
);

  esc_pkg::esc_div_stage_t src [esc_pkg::DivBits];
  esc_pkg::esc_div_stage_t stg_nxt [esc_pkg::DivBits];
  esc_pkg::esc_div_stage_t stg_r [esc_pkg::DivBits];

  always_comb begin
    src[0].vld  = in_vld;
    src[0].rem  = '0;
    src[0].quo  = '0;
    src[0].num  = in_num;
    src[0].den  = in_den;
    src[0].side = in_side;
  end

  genvar k;
  generate
    for (k = 1; k < esc_pkg::DivBits; k++) begin : g_src
      assign src[k] = stg_r[k-1];
    end
    for (k = 0; k < esc_pkg::DivBits; k++) begin : g_stage
      logic [32:0] trial;
      logic [32:0] diff;
      always_comb begin
        trial = {src[k].rem, src[k].num[31]};
        diff  = trial - {1'b0, src[k].den};
        stg_nxt[k] = src[k];
        stg_nxt[k].num = {src[k].num[30:0], 1'b0};
        if (!diff[32]) begin
          stg_nxt[k].rem = diff[31:0];
          stg_nxt[k].quo = {src[k].quo[30:0], 1'b1};
        end else begin
          stg_nxt[k].rem = trial[31:0];
          stg_nxt[k].quo = {src[k].quo[30:0], 1'b0};
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg_r[k].vld <= 1'b0;
        end else if (en) begin
          stg_r[k].vld <= stg_nxt[k].vld;
        end
        if (en) begin
          stg_r[k].rem  <= stg_nxt[k].rem;
          stg_r[k].quo  <= stg_nxt[k].quo;
          stg_r[k].num  <= stg_nxt[k].num;
          stg_r[k].den  <= stg_nxt[k].den;
          stg_r[k].side <= stg_nxt[k].side;
        end
      end
    end
  endgenerate

  assign out_vld  = stg_r[esc_pkg::DivBits-1].vld;
  assign out_quo  = stg_r[esc_pkg::DivBits-1].quo;
  assign out_side = stg_r[esc_pkg::DivBits-1].side;

endmodule

`default_nettype wire

@@ hw/rtl/esc_checker.sv @@
// port-level checker for env_sensor_compensation, attached by bind
// depends on esc_pkg and env_sensor_compensation_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "env_sensor_compensation_assert.svh"

module esc_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire esc_pkg::esc_out_t out_data
);

  `ESC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
  `ESC_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_data))
  `ESC_ASSERT_ALWAYS(a_stall_cause, in_stall |-> out_valid && out_stall)
  `ESC_ASSERT(a_press_zero, out_valid && !out_data.pressure_valid |-> out_data.air_pressure == 32'd0)
  `ESC_ASSERT(a_hum_range, out_valid |-> out_data.humidity_q10 <= 17'd102400)

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
